[sv/cidv_pkg.sv]
// ----------------------------------------------------------------------------
// Content ID string validator package
// Shared types, codes and defaults for the ID string validator.
// ----------------------------------------------------------------------------
`default_nettype none

package cidv_pkg;

  localparam int MAX_SEGMENT_LEN_DEF = 64;
  localparam int MAX_ID_LEN_DEF      = 256;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] CFG_KIND_BYTES = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_KIND_LEN   = CFG_INDEX_W'(1);

  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_EMPTY        = 4'd1;
  localparam logic [3:0] ERR_EMPTY_SEG    = 4'd2;
  localparam logic [3:0] ERR_TOO_LONG     = 4'd3;
  localparam logic [3:0] ERR_NON_ASCII    = 4'd4;
  localparam logic [3:0] ERR_BAD_START    = 4'd5;
  localparam logic [3:0] ERR_BAD_CHAR     = 4'd6;
  localparam logic [3:0] ERR_SEPARATOR    = 4'd7;
  localparam logic [3:0] ERR_WRONG_KIND   = 4'd8;
  localparam logic [3:0] ERR_BAD_INSTANCE = 4'd9;

  localparam logic [1:0] MODE_STABLE   = 2'd0;
  localparam logic [1:0] MODE_KIND     = 2'd1;
  localparam logic [1:0] MODE_INSTANCE = 2'd2;

  localparam logic [1:0] REGION_FIRST  = 2'd0;
  localparam logic [1:0] REGION_SECOND = 2'd1;
  localparam logic [1:0] REGION_PATH   = 2'd2;

  localparam logic [7:0] CH_ASCII_MAX   = 8'h7f;
  localparam logic [7:0] CH_UNDERSCORE  = 8'h5f;
  localparam logic [7:0] CH_COLON       = 8'h3a;
  localparam logic [7:0] CH_DOT         = 8'h2e;
  localparam logic [7:0] CH_AT          = 8'h40;
  localparam logic [7:0] CH_ZERO        = 8'h30;
  localparam logic [7:0] CH_NINE        = 8'h39;
  localparam logic [7:0] CH_LOWER_A     = 8'h61;
  localparam logic [7:0] CH_LOWER_Z     = 8'h7a;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       empty_string;
    logic [1:0] mode;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  error_code;
    logic [6:0]  namespace_len;
    logic [6:0]  kind_len;
    logic [8:0]  path_len;
    logic [63:0] counter_value;
  } result_t;

endpackage

`default_nettype wire

[sv/cidv_core.sv]
// ----------------------------------------------------------------------------
// ID string validator core
// Per-byte string state and the end-of-string result, updated once per step.
// ----------------------------------------------------------------------------
`default_nettype none

module cidv_core #(
  parameter int MAX_SEGMENT_LEN = cidv_pkg::MAX_SEGMENT_LEN_DEF,
  parameter int MAX_ID_LEN      = cidv_pkg::MAX_ID_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  cidv_pkg::in_item_t item,
  input  logic [63:0]        kind_bytes,
  input  logic [3:0]         kind_len,
  output logic               produce,
  output cidv_pkg::result_t  result
);
  import cidv_pkg::*;

  localparam int SEG_CAP = (MAX_SEGMENT_LEN > MAX_ID_LEN) ? MAX_SEGMENT_LEN : MAX_ID_LEN;
  localparam int SL_W    = $clog2(SEG_CAP + 2);
  localparam int TL_W    = $clog2(MAX_ID_LEN + 2);
  localparam int FL_W    = $clog2(MAX_SEGMENT_LEN + 2);
  localparam int PW      = (TL_W > 9) ? TL_W : 9;
  localparam int KW      = (SL_W > 4) ? SL_W : 4;

  logic [1:0]      latched_mode, latched_mode_next;
  logic            in_string, in_string_next;
  logic [TL_W-1:0] total_length, total_length_next;
  logic [1:0]      region, region_next;
  logic [1:0]      separator_count, separator_count_next;
  logic            dot_after_colon, dot_after_colon_next;
  logic [SL_W-1:0] segment_length, segment_length_next;
  logic [3:0]      segment_pending_error, segment_pending_error_next;
  logic [3:0]      first_segment_error, first_segment_error_next;
  logic [FL_W-1:0] field_len0, field_len0_next;
  logic [FL_W-1:0] field_len1, field_len1_next;
  logic [63:0]     counter_accum, counter_accum_next;
  logic [3:0]      counter_error, counter_error_next;
  logic            kind_matches, kind_matches_next;

  logic [7:0]      c;
  logic            is_digit;
  logic            inst;
  logic [67:0]     prod;
  logic [3:0]      fin_err;
  logic [3:0]      fin_first;
  logic [PW-1:0]   path;

  function automatic logic [3:0] char_error(input logic [7:0] ch, input logic at_start);
    logic lo;
    logic dg;
    lo = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z);
    dg = (ch >= CH_ZERO) && (ch <= CH_NINE);
    if (ch > CH_ASCII_MAX) begin
      return ERR_NON_ASCII;
    end else if (at_start && !lo) begin
      return ERR_BAD_START;
    end else if (!lo && !dg && (ch != CH_UNDERSCORE)) begin
      return ERR_BAD_CHAR;
    end
    return ERR_NONE;
  endfunction

  function automatic logic [3:0] close_error(input logic [SL_W-1:0] len,
                                             input logic [3:0] pend);
    if (len == '0) begin
      return ERR_EMPTY_SEG;
    end else if (len > SL_W'(MAX_SEGMENT_LEN)) begin
      return ERR_TOO_LONG;
    end
    return pend;
  endfunction

  always_comb begin
    logic [3:0] ce;
    logic [3:0] be;
    c        = item.char_code;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    produce  = item.empty_string || item.last_char;
    result   = '0;

    // A new string starts from cleared state.
    latched_mode_next          = in_string ? latched_mode : item.mode;
    in_string_next             = 1'b1;
    total_length_next          = in_string ? total_length : '0;
    region_next                = in_string ? region : REGION_FIRST;
    separator_count_next       = in_string ? separator_count : 2'd0;
    dot_after_colon_next       = in_string ? dot_after_colon : 1'b0;
    segment_length_next        = in_string ? segment_length : '0;
    segment_pending_error_next = in_string ? segment_pending_error : ERR_NONE;
    first_segment_error_next   = in_string ? first_segment_error : ERR_NONE;
    field_len0_next            = in_string ? field_len0 : '0;
    field_len1_next            = in_string ? field_len1 : '0;
    counter_accum_next         = in_string ? counter_accum : '0;
    counter_error_next         = in_string ? counter_error : ERR_NONE;
    kind_matches_next          = in_string ? kind_matches : 1'b1;

    if (total_length_next <= TL_W'(MAX_ID_LEN)) begin
      total_length_next = total_length_next + TL_W'(1);
    end

    inst = (latched_mode_next == MODE_INSTANCE);
    ce   = close_error(segment_length_next, segment_pending_error_next);
    be   = char_error(c, segment_length_next == '0);
    prod = ({4'b0, counter_accum_next} << 3) + ({4'b0, counter_accum_next} << 1)
           + 68'(c[3:0]);

    if (!inst) begin
      if (c == CH_COLON) begin
        if (separator_count_next == 2'd0) begin
          field_len0_next = FL_W'(segment_length_next);
          if (first_segment_error_next == ERR_NONE) first_segment_error_next = ce;
          segment_length_next        = '0;
          segment_pending_error_next = ERR_NONE;
          region_next                = REGION_SECOND;
        end
        if (separator_count_next < 2'd2) separator_count_next = separator_count_next + 2'd1;
      end else if ((c == CH_DOT) && (region_next == REGION_SECOND)) begin
        if (KW'(segment_length_next) != KW'(kind_len)) kind_matches_next = 1'b0;
        field_len1_next = FL_W'(segment_length_next);
        if (first_segment_error_next == ERR_NONE) first_segment_error_next = ce;
        segment_length_next        = '0;
        segment_pending_error_next = ERR_NONE;
        region_next                = REGION_PATH;
        dot_after_colon_next       = 1'b1;
      end else if ((c == CH_DOT) && (region_next == REGION_PATH)) begin
        if (first_segment_error_next == ERR_NONE) first_segment_error_next = ce;
        segment_length_next        = '0;
        segment_pending_error_next = ERR_NONE;
      end else begin
        if (region_next == REGION_SECOND) begin
          if ((KW'(segment_length_next) >= KW'(8)) ||
              (KW'(segment_length_next) >= KW'(kind_len)) ||
              (kind_bytes[{segment_length_next[2:0], 3'b000} +: 8] != c)) begin
            kind_matches_next = 1'b0;
          end
        end
        if (segment_pending_error_next == ERR_NONE) segment_pending_error_next = be;
        if (segment_length_next <= SL_W'(MAX_SEGMENT_LEN)) begin
          segment_length_next = segment_length_next + SL_W'(1);
        end
      end
    end else begin
      if ((c == CH_AT) && (separator_count_next == 2'd0)) begin
        field_len1_next = FL_W'(segment_length_next);
        if (first_segment_error_next == ERR_NONE) first_segment_error_next = ce;
        segment_length_next        = '0;
        segment_pending_error_next = ERR_NONE;
        region_next                = REGION_SECOND;
        separator_count_next       = 2'd1;
      end else begin
        if ((c == CH_AT) && (separator_count_next < 2'd2)) begin
          separator_count_next = separator_count_next + 2'd1;
        end
        if (region_next == REGION_FIRST) begin
          if (segment_pending_error_next == ERR_NONE) segment_pending_error_next = be;
          if (segment_length_next <= SL_W'(MAX_SEGMENT_LEN)) begin
            segment_length_next = segment_length_next + SL_W'(1);
          end
        end else begin
          if (counter_error_next == ERR_NONE) begin
            if (!is_digit || ((segment_length_next == '0) && (c == CH_ZERO))) begin
              counter_error_next = ERR_BAD_INSTANCE;
            end else if (prod[67:64] != 4'd0) begin
              counter_error_next = ERR_TOO_LONG;
            end else begin
              counter_accum_next = prod[63:0];
            end
          end
          if (segment_length_next <= SL_W'(MAX_ID_LEN)) begin
            segment_length_next = segment_length_next + SL_W'(1);
          end
        end
      end
    end

    // End-of-string result.
    fin_first = (first_segment_error_next != ERR_NONE) ? first_segment_error_next
              : close_error(segment_length_next, segment_pending_error_next);
    if (total_length_next > TL_W'(MAX_ID_LEN)) begin
      fin_err = ERR_TOO_LONG;
    end else if (separator_count_next != 2'd1) begin
      fin_err = ERR_SEPARATOR;
    end else if (inst) begin
      if (first_segment_error_next != ERR_NONE) begin
        fin_err = first_segment_error_next;
      end else if (segment_length_next == '0) begin
        fin_err = ERR_BAD_INSTANCE;
      end else begin
        fin_err = counter_error_next;
      end
    end else if (!dot_after_colon_next) begin
      fin_err = ERR_SEPARATOR;
    end else if (fin_first != ERR_NONE) begin
      fin_err = fin_first;
    end else if ((latched_mode_next == MODE_KIND) && !kind_matches_next) begin
      fin_err = ERR_WRONG_KIND;
    end else begin
      fin_err = ERR_NONE;
    end

    path = PW'(total_length_next) - PW'(field_len0_next) - PW'(field_len1_next) - PW'(2);

    if (item.empty_string) begin
      in_string_next    = 1'b0;
      result.error_code = ERR_EMPTY;
    end else if (item.last_char) begin
      in_string_next    = 1'b0;
      result.ok         = (fin_err == ERR_NONE);
      result.error_code = fin_err;
      if (fin_err == ERR_NONE) begin
        result.kind_len = 7'(field_len1_next);
        if (inst) begin
          result.counter_value = counter_accum_next;
        end else begin
          result.namespace_len = 7'(field_len0_next);
          result.path_len      = path[8:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_string <= 1'b0;
    end else if (step) begin
      in_string <= in_string_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      latched_mode          <= latched_mode_next;
      total_length          <= total_length_next;
      region                <= region_next;
      separator_count       <= separator_count_next;
      dot_after_colon       <= dot_after_colon_next;
      segment_length        <= segment_length_next;
      segment_pending_error <= segment_pending_error_next;
      first_segment_error   <= first_segment_error_next;
      field_len0            <= field_len0_next;
      field_len1            <= field_len1_next;
      counter_accum         <= counter_accum_next;
      counter_error         <= counter_error_next;
      kind_matches          <= kind_matches_next;
    end
  end

endmodule

`default_nettype wire

[sv/content_id_string_validator_unit.sv]
// ----------------------------------------------------------------------------
// Content ID string validator
// Validates one ID string per run, one byte per transfer, and returns one
// result per string.
//
// Each byte arrives as one transfer on the item channel (item_valid,
// item_ready, item). The mode is taken from the first byte of a string;
// last_char closes the string and empty_string answers at once. One result
// transfer per string leaves on the result channel (result_valid,
// result_ready, result).
// The expected kind is written through the cfg channel (index 0: kind
// bytes, index 1: kind length); the user must write it only while no string
// is in progress, which the block does not enforce. cfg_ready is always high.
// A closing byte is held in the input register; the result register is
// loaded from it when the core steps on that byte, and result_valid rises
// as it is loaded.
// Throughput: one byte per cycle, except while a closing byte waits for a
// free result register. When the receiver stalls, bytes that produce no
// result still flow; a closing byte waits in the input register until the
// result register is free. Reset clears the in-string flag, the kind
// registers and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module content_id_string_validator_unit #(
  parameter int MAX_SEGMENT_LEN = cidv_pkg::MAX_SEGMENT_LEN_DEF,
  parameter int MAX_ID_LEN      = cidv_pkg::MAX_ID_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  cidv_pkg::in_item_t                   item,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output cidv_pkg::result_t                    result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cidv_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cidv_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cidv_pkg::*;

  logic        pend_valid;
  in_item_t    pend_item;
  logic [63:0] kind_bytes;
  logic [3:0]  kind_len;
  logic        core_step;
  result_t     core_result;
  logic        core_produce;

  assign cfg_ready  = 1'b1;
  assign core_step  = pend_valid && (!core_produce || !result_valid || result_ready);
  assign item_ready = !pend_valid || core_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind_bytes <= '0;
      kind_len   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KIND_BYTES: kind_bytes <= cfg_data[63:0];
        CFG_KIND_LEN:   kind_len   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (item_ready) begin
      pend_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      pend_item <= item;
    end
  end

  cidv_core #(
    .MAX_SEGMENT_LEN(MAX_SEGMENT_LEN),
    .MAX_ID_LEN     (MAX_ID_LEN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (core_step),
    .item      (pend_item),
    .kind_bytes(kind_bytes),
    .kind_len  (kind_len),
    .produce   (core_produce),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (core_step && core_produce) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_step && core_produce) begin
      result <= core_result;
    end
  end

  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !item_ready) |-> (result_valid && !result_ready))
    else $error("input register stalled while the result register was free");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (core_step && core_produce) |=> result_valid)
    else $error("closing byte processed without a result");

  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.ok == (result.error_code == ERR_NONE)))
    else $error("ok flag disagrees with error code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.ok) |->
      (result.namespace_len == 7'd0 && result.kind_len == 7'd0 &&
       result.path_len == 9'd0 && result.counter_value == 64'd0))
    else $error("failed result carries nonzero fields");

endmodule

`default_nettype wire
